// ===== rtl/alil_pkg.sv =====
// ----------------------------------------------------------------------------
// Ambient light log illuminance: shared package
// Field widths, arithmetic constants, the log table and the control codes
// that are shared by the block's modules.
// ----------------------------------------------------------------------------
package alil_pkg;

   // Converter width and derived field widths.
   localparam int ADC_BITS = 12;
   localparam int LVL_W    = 12;
   localparam int WGT_W    = 12;
   localparam int STEPS_W  = 9;
   localparam int SENS_W   = 8;
   localparam int ILLUM_W  = 9;

   // Resistance arithmetic: 409500000 / level - 100000.
   localparam int QUOT_W = 29;
   localparam int CNT_W  = $clog2(QUOT_W + 1);
   localparam logic [QUOT_W-1:0] DIVIDEND_FULL = QUOT_W'(409500000);
   localparam logic [QUOT_W-1:0] SERIES_OHMS   = QUOT_W'(100000);

   // Log arithmetic: 40*log2(R) fits 11 bits, the offset is 642 + 30*5.
   localparam int LOG_W   = 11;
   localparam int NUM_W   = 10;
   localparam logic [LOG_W-1:0] LOG_OFFSET = LOG_W'(642 + (30 * 5));
   // floor(n/3) == (n*683) >> 11 for every n below 2047.
   localparam logic [NUM_W-1:0] RECIP3     = NUM_W'(683);
   localparam int RECIP3_SHIFT = 11;

   // Register reset values.
   localparam logic [WGT_W-1:0]   WEIGHT_RESET = WGT_W'(128);
   localparam logic [STEPS_W-1:0] STEPS_RESET  = STEPS_W'(256);
   localparam logic [STEPS_W-1:0] STEPS_MAX    = STEPS_W'(256);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_WEIGHT = 1'b0,
      CSR_SENS_STEPS    = 1'b1
   } alil_csr_type;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILT,
      ST_DIV,
      ST_NORM,
      ST_LOG,
      ST_OUT
   } alil_state_type;

   // Status that each serial unit reports to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } alil_unit_stat_type;

   // 40*log2 of a 4-bit mantissa, rounded.
   function automatic logic [7:0] log40_lut(input logic [3:0] idx);
      logic [7:0] val;
      case (idx)
         4'd0:    val = 8'd0;
         4'd1:    val = 8'd0;
         4'd2:    val = 8'd40;
         4'd3:    val = 8'd63;
         4'd4:    val = 8'd80;
         4'd5:    val = 8'd93;
         4'd6:    val = 8'd103;
         4'd7:    val = 8'd112;
         4'd8:    val = 8'd120;
         4'd9:    val = 8'd127;
         4'd10:   val = 8'd133;
         4'd11:   val = 8'd138;
         4'd12:   val = 8'd143;
         4'd13:   val = 8'd148;
         4'd14:   val = 8'd152;
         default: val = 8'd156;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/alil_req_if.sv =====
// ----------------------------------------------------------------------------
// Ambient light request channel
// Valid/ready channel that carries one light sample and one pot sample.
// ----------------------------------------------------------------------------
interface alil_req_if
   import alil_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] light_sample;
   logic [ADC_BITS-1:0] pot_sample;

   modport source (output valid, output light_sample, output pot_sample, input ready);
   modport sink   (input valid, input light_sample, input pot_sample, output ready);
endinterface

// ===== rtl/alil_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Ambient light response channel
// Valid/ready channel that carries the filtered level, log illuminance,
// sensitivity step and zero-level flag of one request.
// ----------------------------------------------------------------------------
interface alil_rsp_if
   import alil_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [LVL_W-1:0]   filtered_level;
   logic [ILLUM_W-1:0] log_illuminance;
   logic [SENS_W-1:0]  sensitivity;
   logic               zero_level;

   modport source (output valid, output filtered_level, output log_illuminance,
                   output sensitivity, output zero_level, input ready);
   modport sink   (input valid, input filtered_level, input log_illuminance,
                   input sensitivity, input zero_level, output ready);
endinterface

// ===== rtl/alil_div.sv =====
// ----------------------------------------------------------------------------
// Ambient light resistance divider
// Restoring divider that produces one quotient bit per cycle of the fixed
// dividend over the 12-bit filtered level.
// ----------------------------------------------------------------------------
module alil_div
   import alil_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [LVL_W-1:0]   divisor,
   output logic [QUOT_W-1:0]  quotient,
   output alil_unit_stat_type stat
);

   logic [QUOT_W-1:0] dq_ff, dq_in;
   logic [LVL_W-1:0]  rem_ff, rem_in;
   logic [LVL_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [LVL_W:0]    trial;
   logic [LVL_W:0]    diff;
   logic              fits;

   // One restoring step: bring down the next dividend bit and try a subtract.
   always_comb begin
      trial  = {rem_ff, dq_ff[QUOT_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = (trial >= {1'b0, dvs_ff});
      rem_in = fits ? diff[LVL_W-1:0] : trial[LVL_W-1:0];
      dq_in  = {dq_ff[QUOT_W-2:0], fits};
   end

   // Step counter and status.
   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         cnt_in  = CNT_W'(QUOT_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Dividend/quotient shift register, remainder and divisor.
   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= DIVIDEND_FULL;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient  = dq_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== rtl/alil_norm.sv =====
// ----------------------------------------------------------------------------
// Ambient light log normalizer
// Takes the quotient, removes the series resistance, then shifts the
// resistance left one bit per cycle until its leading one reaches the top.
// The shift count and top four bits give 40*log2 of the resistance.
// ----------------------------------------------------------------------------
module alil_norm
   import alil_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [QUOT_W-1:0]  quotient,
   output logic [LOG_W-1:0]   log40,
   output alil_unit_stat_type stat
);

   localparam int MSB_W = $clog2(QUOT_W);

   logic [QUOT_W-1:0] nr_ff;
   logic [3:0]        rlow_ff;
   logic [MSB_W-1:0]  msb_ff;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [QUOT_W-1:0] res;
   logic [LOG_W-1:0]  octave;

   // Resistance is the quotient minus the series resistor, at least one.
   always_comb begin
      if (quotient <= SERIES_OHMS) begin
         res = QUOT_W'(1);
      end else begin
         res = quotient - SERIES_OHMS;
      end
   end

   // Status: done once the leading one sits in the top bit.
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff && nr_ff[QUOT_W-1]) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Normalizing shift register and leading-one index.
   always_ff @(posedge clock) begin
      if (start) begin
         nr_ff   <= res;
         rlow_ff <= res[3:0];
         msb_ff  <= MSB_W'(QUOT_W - 1);
      end else if (busy_ff && !nr_ff[QUOT_W-1]) begin
         nr_ff  <= {nr_ff[QUOT_W-2:0], 1'b0};
         msb_ff <= msb_ff - 1'b1;
      end
   end

   // Small values read the table directly; otherwise whole octaves plus
   // the table entry of the top four bits.
   always_comb begin
      octave = LOG_W'(msb_ff - MSB_W'(3)) * LOG_W'(40);
      if (msb_ff >= MSB_W'(3)) begin
         log40 = octave + LOG_W'(log40_lut(nr_ff[QUOT_W-1 -: 4]));
      end else begin
         log40 = LOG_W'(log40_lut(rlow_ff));
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== rtl/alil_scale.sv =====
// ----------------------------------------------------------------------------
// Ambient light sensitivity scaler
// Bit-serial shift-and-add multiply of the pot sample by steps-1, one
// multiplier bit per cycle from the top, followed by a rounding shift.
// ----------------------------------------------------------------------------
module alil_scale
   import alil_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ADC_BITS-1:0] pot,
   input  logic [SENS_W-1:0]   factor,
   output logic [SENS_W-1:0]   sensitivity,
   output alil_unit_stat_type  stat
);

   localparam int ACC_W = ADC_BITS + SENS_W;
   localparam int IDX_W = $clog2(SENS_W);

   logic [ACC_W-1:0]    acc_ff;
   logic [ADC_BITS-1:0] pot_ff;
   logic [SENS_W-1:0]   fac_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [ACC_W-1:0]    addend;
   logic [ACC_W:0]      rounded;

   assign addend = fac_ff[idx_ff] ? ACC_W'(pot_ff) : '0;

   // Status: the last step is the one on the lowest factor bit.
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff && (idx_ff == '0)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Accumulator, operands and bit index.
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         pot_ff <= pot;
         fac_ff <= factor;
         idx_ff <= IDX_W'(SENS_W - 1);
      end else if (busy_ff) begin
         acc_ff <= {acc_ff[ACC_W-2:0], 1'b0} + addend;
         idx_ff <= idx_ff - 1'b1;
      end
   end

   // Round by half a converter step and drop the fraction.
   assign rounded     = {1'b0, acc_ff} + (ACC_W+1)'(1 << (ADC_BITS - 1));
   assign sensitivity = rounded[ADC_BITS +: SENS_W];
   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;

endmodule

// ===== rtl/ambient_light_log_illuminance.sv =====
// ----------------------------------------------------------------------------
// Ambient light log illuminance
// Low-pass filters a light sample, derives the photoresistor resistance and
// its log illuminance, and scales a pot sample to a sensitivity step.
//
//   Channel   Direction  Handshake      Contents
//   req_chan  in         valid/ready    light_sample, pot_sample
//   rsp_chan  out        valid/ready    filtered_level, log_illuminance,
//                                       sensitivity, zero_level
//   csr_*     in         write enable   filter_weight, sensitivity_steps
//
// One request is in flight at a time. Between acceptances the sequencer
// walks the filter, divide, normalize, log and output states; the bit-serial
// divider and the one-bit-per-cycle normalizer, whose run grows with the
// leading zeros of the 29-bit resistance, set how long that takes.
// Reset is synchronous and active high; it clears the filter level and loads
// the register defaults. A response waits in an output register, so a new
// request is taken while it is stalled; the block holds only if that
// register is still full when the next response is ready.
// ----------------------------------------------------------------------------
module ambient_light_log_illuminance
   import alil_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   alil_req_if.sink             req_chan,
   alil_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WGT_W-1:0]     csr_wdata
);

   alil_state_type state_ff, state_in;

   logic [WGT_W-1:0]    weight_ff;
   logic [STEPS_W-1:0]  steps_ff;
   logic [LVL_W-1:0]    level_ff;
   logic [ADC_BITS-1:0] light_ff;
   logic [ADC_BITS-1:0] pot_ff;
   logic                zero_ff;
   logic [NUM_W-1:0]    num_ff;

   logic                rsp_valid_ff;
   logic [LVL_W-1:0]    rsp_level_ff;
   logic [ILLUM_W-1:0]  rsp_illum_ff;
   logic [SENS_W-1:0]   rsp_sens_ff;
   logic                rsp_zero_ff;

   logic                req_take;
   logic                unit_start;
   logic                norm_start;
   logic                rsp_load;

   logic signed [LVL_W:0]     lvl_diff;
   logic signed [2*LVL_W+1:0] lvl_prod;
   logic signed [2*LVL_W+1:0] lvl_acc;
   logic [LVL_W-1:0]          lvl_new;
   logic                      lvl_zero;
   logic [LVL_W-1:0]          divisor;
   logic [STEPS_W-1:0]        steps_eff;
   logic [SENS_W-1:0]         factor;
   logic [2*NUM_W-1:0]        illum_prod;

   logic [QUOT_W-1:0]   quotient;
   logic [LOG_W-1:0]    log40;
   logic [SENS_W-1:0]   sens;
   alil_unit_stat_type  div_stat;
   alil_unit_stat_type  norm_stat;
   alil_unit_stat_type  scale_stat;

   // Filter step: level + (x - level)*w / 4096, rounded toward the sample.
   always_comb begin
      lvl_diff = $signed({1'b0, light_ff}) - $signed({1'b0, level_ff});
      lvl_prod = lvl_diff * $signed({1'b0, weight_ff});
      lvl_acc  = $signed({2'b00, level_ff, {ADC_BITS{1'b0}}}) + lvl_prod
               + ((light_ff > level_ff) ? (2*LVL_W+2)'((1 << ADC_BITS) - 1)
                                        : (2*LVL_W+2)'(0));
      lvl_new  = lvl_acc[ADC_BITS +: LVL_W];
      lvl_zero = (lvl_new == '0);
      divisor  = lvl_zero ? LVL_W'(1) : lvl_new;
   end

   // Sensitivity step count limited to 1..256, used as steps-1.
   always_comb begin
      if (steps_ff > STEPS_MAX) begin
         steps_eff = STEPS_MAX;
      end else if (steps_ff == '0) begin
         steps_eff = STEPS_W'(1);
      end else begin
         steps_eff = steps_ff;
      end
      factor = SENS_W'(steps_eff - STEPS_W'(1));
   end

   // Serial units.
   alil_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .divisor  (divisor),
      .quotient (quotient),
      .stat     (div_stat)
   );

   alil_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .start    (norm_start),
      .quotient (quotient),
      .log40    (log40),
      .stat     (norm_stat)
   );

   alil_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .start       (unit_start),
      .pot         (pot_ff),
      .factor      (factor),
      .sensitivity (sens),
      .stat        (scale_stat)
   );

   // Sequencer: next state and control.
   always_comb begin
      state_in   = state_ff;
      req_take   = 1'b0;
      unit_start = 1'b0;
      norm_start = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_take = 1'b1;
            if (req_chan.valid) begin
               state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            unit_start = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               norm_start = 1'b1;
               state_in   = ST_NORM;
            end
         end
         ST_NORM: begin
            if (norm_stat.done) begin
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHT_RESET;
         steps_ff  <= STEPS_RESET;
         level_ff  <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_FILTER_WEIGHT: weight_ff <= csr_wdata;
               CSR_SENS_STEPS:    steps_ff  <= csr_wdata[STEPS_W-1:0];
            endcase
         end
         if (state_ff == ST_FILT) begin
            level_ff <= lvl_new;
         end
      end
   end

   // Request payload and intermediate results.
   always_ff @(posedge clock) begin
      if (req_take && req_chan.valid) begin
         light_ff <= req_chan.light_sample;
         pot_ff   <= req_chan.pot_sample;
      end
      if (state_ff == ST_FILT) begin
         zero_ff <= lvl_zero;
      end
      if (state_ff == ST_LOG) begin
         num_ff <= (log40 > LOG_OFFSET) ? '0 : NUM_W'(LOG_OFFSET - log40);
      end
   end

   // Divide by three through the reciprocal.
   assign illum_prod = num_ff * RECIP3;

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_level_ff <= level_ff;
         rsp_illum_ff <= illum_prod[RECIP3_SHIFT +: ILLUM_W];
         rsp_sens_ff  <= sens;
         rsp_zero_ff  <= zero_ff;
      end
   end

   assign req_chan.ready           = req_take;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.filtered_level  = rsp_level_ff;
   assign rsp_chan.log_illuminance = rsp_illum_ff;
   assign rsp_chan.sensitivity     = rsp_sens_ff;
   assign rsp_chan.zero_level      = rsp_zero_ff;

`ifndef SYNTH
   // The shorter scaler has finished whenever the divider has.
   a_scale_before_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_stat.done) |-> scale_stat.done)
      else $error("scaler still busy when divider finished");

   // An accepted request starts the filter step on the next cycle.
   a_accept_to_filt: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_FILT))
      else $error("accepted request did not enter the filter step");

   // A zero level always yields the darkest reading.
   a_zero_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_zero_ff) |-> (rsp_level_ff == '0 && rsp_illum_ff == '0))
      else $error("zero level response with nonzero level or illuminance");
`endif

endmodule
